// ===== rtl/first_fit_byte_pool_allocator_defines.svh =====
// Assertion macros for the byte pool allocator checks.
`ifndef FIRST_FIT_BYTE_POOL_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BYTE_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, skipped while reset is low.
`define FFBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffbpa check failed");

// Next-cycle implication, skipped while reset is low.
`define FFBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffbpa check failed");

`endif

// ===== rtl/ffbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbpa_pkg
// Types and constants shared by the byte pool allocator and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffbpa_pkg;

    localparam int POOL_BYTES = 256;
    localparam int ADDR_W     = $clog2(POOL_BYTES);
    localparam int LEN_W      = $clog2(POOL_BYTES) + 1;

    localparam logic [7:0] MARK_USED = 8'h75;
    localparam logic [7:0] MARK_FREE = 8'h66;
    localparam logic [7:0] HDR_BYTES = 8'd2;
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(4);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(POOL_BYTES);

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_COMPACT = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_FIT   = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT_MARK,
        ST_INIT_LEN,
        ST_IDLE,
        ST_HDR,
        ST_MARK,
        ST_LEN,
        ST_ALLOC_W1,
        ST_ALLOC_W2,
        ST_ALLOC_W3,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/first_fit_byte_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_byte_pool_allocator
// First-fit allocator over a byte pool of two-byte block headers, with free,
// compaction of adjacent free blocks and whole-pool release.
// ----------------------------------------------------------------------------
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+----------------------------------------
//  command  | i_valid     | o_ready     | i_command, i_request_size, i_block_offset
//  result   | o_valid     | i_ready     | o_status, o_granted_offset, o_largest_free
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_pool_length
//
//  One item at a time. The header walk reads mark and length through the single
//  pool memory read port: ST_HDR, ST_MARK and ST_LEN per visited header, ST_HDR
//  at pool end, ST_ALLOC_W1 to ST_ALLOC_W3 for an allocate split, then ST_DONE
//  loads the result. Release, a config write and reset rewrite the first header
//  in ST_INIT_MARK and ST_INIT_LEN; after reset the block takes no item until
//  both are done. A stalled result holds the block in its final state until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_byte_pool_allocator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_request_size,
    input  wire logic [7:0] i_block_offset,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_granted_offset,
    output logic [7:0]      o_largest_free,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [8:0] i_cfg_pool_length
);

    localparam int AW = ffbpa_pkg::ADDR_W;
    localparam int LW = ffbpa_pkg::LEN_W;

    ffbpa_pkg::t_state r_state, n_state;

    logic [7:0]    mem [ffbpa_pkg::POOL_BYTES];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [8:0]    r_pool_len, n_pool_len;
    logic          r_respond, n_respond;
    logic [1:0]    r_cmd, n_cmd;
    logic [7:0]    r_size, n_size;
    logic [7:0]    r_off, n_off;
    logic [LW-1:0] r_idx, n_idx;
    logic [7:0]    r_mark, n_mark;
    logic [7:0]    r_len, n_len;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_granted, n_granted;
    logic [7:0]    r_best, n_best;
    logic          r_in_run, n_in_run;
    logic [LW-1:0] r_run_start, n_run_start;
    logic [LW-1:0] r_run_bytes, n_run_bytes;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [7:0]    r_out_granted, n_out_granted;
    logic [7:0]    r_out_largest, n_out_largest;

    logic [LW-1:0] w_eff;
    logic [LW:0]   w_hdr_end;
    logic [LW:0]   w_blk_end;
    logic          w_hdr_fit;
    logic          w_blk_fit;
    logic          w_room;
    logic          w_is_free;
    logic          w_is_used;
    logic          w_hit;
    logic          w_past;
    logic [7:0]    w_rest;
    logic [7:0]    w_pay;
    logic          w_better;
    logic [LW-1:0] w_run_sum;
    logic          w_cfg_acc;
    logic          w_in_acc;
    logic          w_out_load;

    assign o_cfg_ready = (r_state == ffbpa_pkg::ST_IDLE);
    assign o_ready     = (r_state == ffbpa_pkg::ST_IDLE) && !i_cfg_valid;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_load  = (r_state == ffbpa_pkg::ST_DONE) && (!r_out_valid || i_ready);

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_granted_offset = r_out_granted;
    assign o_largest_free   = r_out_largest;

    always_comb begin
        if (r_pool_len < ffbpa_pkg::MIN_LEN) begin
            w_eff = ffbpa_pkg::MIN_LEN;
        end else if (r_pool_len > ffbpa_pkg::MAX_LEN) begin
            w_eff = ffbpa_pkg::MAX_LEN;
        end else begin
            w_eff = LW'(r_pool_len);
        end
    end

    // Shared walk adder: header end, then block end, which is also the next index.
    assign w_hdr_end = (LW+1)'(r_idx) + (LW+1)'(ffbpa_pkg::HDR_BYTES);
    assign w_blk_end = w_hdr_end + (LW+1)'(r_rdata);
    assign w_hdr_fit = w_hdr_end <= (LW+1)'(w_eff);
    assign w_blk_fit = w_blk_end <= (LW+1)'(w_eff);
    assign w_room    = 9'(r_rdata) >= (9'(r_size) + 9'(ffbpa_pkg::HDR_BYTES));
    assign w_is_free = (r_mark == ffbpa_pkg::MARK_FREE);
    assign w_is_used = (r_mark == ffbpa_pkg::MARK_USED);
    assign w_hit     = (r_idx == LW'(r_off));
    assign w_past    = (r_idx > LW'(r_off));
    assign w_rest    = r_idx[AW-1:0] + ffbpa_pkg::HDR_BYTES + r_size;
    assign w_pay     = 8'(r_run_bytes - LW'(ffbpa_pkg::HDR_BYTES));
    assign w_better  = w_pay > r_best;
    assign w_run_sum = r_run_bytes + LW'(r_rdata) + LW'(ffbpa_pkg::HDR_BYTES);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffbpa_pkg::ST_INIT_MARK: begin
                n_state = ffbpa_pkg::ST_INIT_LEN;
            end
            ffbpa_pkg::ST_INIT_LEN: begin
                n_state = r_respond ? ffbpa_pkg::ST_DONE : ffbpa_pkg::ST_IDLE;
            end
            ffbpa_pkg::ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_state = ffbpa_pkg::ST_INIT_MARK;
                end else if (w_in_acc) begin
                    n_state = (i_command == ffbpa_pkg::CMD_RELEASE) ?
                              ffbpa_pkg::ST_INIT_MARK : ffbpa_pkg::ST_HDR;
                end
            end
            ffbpa_pkg::ST_HDR: begin
                if (!w_hdr_fit || (r_cmd == ffbpa_pkg::CMD_FREE && w_past)) begin
                    n_state = ffbpa_pkg::ST_DONE;
                end else begin
                    n_state = ffbpa_pkg::ST_MARK;
                end
            end
            ffbpa_pkg::ST_MARK: begin
                n_state = ffbpa_pkg::ST_LEN;
            end
            ffbpa_pkg::ST_LEN: begin
                if (!w_blk_fit) begin
                    n_state = ffbpa_pkg::ST_DONE;
                end else if (r_cmd == ffbpa_pkg::CMD_ALLOC && w_is_free && w_room) begin
                    n_state = ffbpa_pkg::ST_ALLOC_W1;
                end else if (r_cmd == ffbpa_pkg::CMD_FREE && w_hit) begin
                    n_state = ffbpa_pkg::ST_DONE;
                end else begin
                    n_state = ffbpa_pkg::ST_HDR;
                end
            end
            ffbpa_pkg::ST_ALLOC_W1: n_state = ffbpa_pkg::ST_ALLOC_W2;
            ffbpa_pkg::ST_ALLOC_W2: n_state = ffbpa_pkg::ST_ALLOC_W3;
            ffbpa_pkg::ST_ALLOC_W3: n_state = ffbpa_pkg::ST_DONE;
            ffbpa_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = ffbpa_pkg::ST_IDLE;
                end
            end
            default: n_state = ffbpa_pkg::ST_INIT_MARK;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_pool_len    = r_pool_len;
        n_respond     = r_respond;
        n_cmd         = r_cmd;
        n_size        = r_size;
        n_off         = r_off;
        n_idx         = r_idx;
        n_mark        = r_mark;
        n_len         = r_len;
        n_status      = r_status;
        n_granted     = r_granted;
        n_best        = r_best;
        n_in_run      = r_in_run;
        n_run_start   = r_run_start;
        n_run_bytes   = r_run_bytes;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_largest = r_out_largest;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = r_idx[AW-1:0];

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ffbpa_pkg::ST_INIT_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = ffbpa_pkg::MARK_FREE;
            end
            ffbpa_pkg::ST_INIT_LEN: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(1);
                mem_wdata = 8'(w_eff - LW'(ffbpa_pkg::HDR_BYTES));
            end
            ffbpa_pkg::ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_pool_len = i_cfg_pool_length;
                    n_respond  = 1'b0;
                end else if (w_in_acc) begin
                    n_cmd     = i_command;
                    n_size    = i_request_size;
                    n_off     = i_block_offset;
                    n_idx     = '0;
                    n_status  = ffbpa_pkg::STAT_OK;
                    n_granted = '0;
                    n_best    = '0;
                    n_in_run  = 1'b0;
                    n_respond = 1'b1;
                end
            end
            ffbpa_pkg::ST_HDR: begin
                if (!w_hdr_fit) begin
                    case (r_cmd)
                        ffbpa_pkg::CMD_ALLOC: n_status = ffbpa_pkg::STAT_NO_FIT;
                        ffbpa_pkg::CMD_FREE:  n_status = ffbpa_pkg::STAT_BAD_FREE;
                        default: ;
                    endcase
                    // close the run in progress at pool end
                    if (r_cmd == ffbpa_pkg::CMD_COMPACT && r_in_run) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_run_start[AW-1:0] + AW'(1);
                        mem_wdata = w_pay;
                        n_in_run  = 1'b0;
                        if (w_better) n_best = w_pay;
                    end
                end else if (r_cmd == ffbpa_pkg::CMD_FREE && w_past) begin
                    n_status = ffbpa_pkg::STAT_BAD_FREE;
                end
            end
            ffbpa_pkg::ST_MARK: begin
                n_mark    = r_rdata;
                mem_raddr = r_idx[AW-1:0] + AW'(1);
            end
            ffbpa_pkg::ST_LEN: begin
                n_len = r_rdata;
                n_idx = w_blk_end[LW-1:0];
                case (r_cmd)
                    ffbpa_pkg::CMD_ALLOC: begin
                        if (!w_blk_fit) begin
                            n_status = ffbpa_pkg::STAT_NO_FIT;
                        end else if (w_is_free && w_room) begin
                            n_idx     = r_idx;
                            n_granted = r_idx[7:0];
                            mem_we    = 1'b1;
                            mem_waddr = r_idx[AW-1:0];
                            mem_wdata = ffbpa_pkg::MARK_USED;
                        end
                    end
                    ffbpa_pkg::CMD_FREE: begin
                        if (!w_blk_fit) begin
                            n_status = ffbpa_pkg::STAT_BAD_FREE;
                        end else if (w_hit) begin
                            if (w_is_used) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_idx[AW-1:0];
                                mem_wdata = ffbpa_pkg::MARK_FREE;
                            end else begin
                                n_status = ffbpa_pkg::STAT_BAD_FREE;
                            end
                        end
                    end
                    ffbpa_pkg::CMD_COMPACT: begin
                        if (w_blk_fit && w_is_free) begin
                            if (r_in_run) begin
                                n_run_bytes = w_run_sum;
                            end else begin
                                n_in_run    = 1'b1;
                                n_run_start = r_idx;
                                n_run_bytes = LW'(r_rdata) + LW'(ffbpa_pkg::HDR_BYTES);
                            end
                        end else if (r_in_run) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_run_start[AW-1:0] + AW'(1);
                            mem_wdata = w_pay;
                            n_in_run  = 1'b0;
                            if (w_better) n_best = w_pay;
                        end
                    end
                    default: ;
                endcase
            end
            ffbpa_pkg::ST_ALLOC_W1: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0] + AW'(1);
                mem_wdata = r_size;
            end
            ffbpa_pkg::ST_ALLOC_W2: begin
                mem_we    = 1'b1;
                mem_waddr = w_rest;
                mem_wdata = ffbpa_pkg::MARK_FREE;
            end
            ffbpa_pkg::ST_ALLOC_W3: begin
                mem_we    = 1'b1;
                mem_waddr = w_rest + AW'(1);
                mem_wdata = r_len - r_size - ffbpa_pkg::HDR_BYTES;
            end
            ffbpa_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_granted = r_granted;
                    n_out_largest = r_best;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffbpa_pkg::ST_INIT_MARK;
            r_pool_len  <= 9'(ffbpa_pkg::POOL_BYTES);
            r_respond   <= 1'b0;
            r_in_run    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool_len  <= n_pool_len;
            r_respond   <= n_respond;
            r_in_run    <= n_in_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_size        <= n_size;
        r_off         <= n_off;
        r_idx         <= n_idx;
        r_mark        <= n_mark;
        r_len         <= n_len;
        r_status      <= n_status;
        r_granted     <= n_granted;
        r_best        <= n_best;
        r_run_start   <= n_run_start;
        r_run_bytes   <= n_run_bytes;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_largest <= n_out_largest;
    end

endmodule

`default_nettype wire

// ===== rtl/ffbpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffbpa_checker
// Port-level checks on the byte pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_byte_pool_allocator_defines.svh"

module ffbpa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [1:0] i_command,
    input wire logic [7:0] i_request_size,
    input wire logic [7:0] i_block_offset,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status,
    input wire logic [7:0] o_granted_offset,
    input wire logic [7:0] o_largest_free,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready,
    input wire logic [8:0] i_cfg_pool_length
);

    logic w_unused;
    assign w_unused = ^{i_command, i_request_size, i_block_offset, i_cfg_pool_length};

    // hold a result beat until taken
    `FFBPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // busy right after taking a command beat
    `FFBPA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_cfg_ready)
    // a granted offset only comes with success
    `FFBPA_ASSERT_NOW(a_grant_ok, i_clk, i_rst_n, o_valid && o_status != ffbpa_pkg::STAT_OK, o_granted_offset == 8'd0 && o_largest_free == 8'd0)
    // compact reports no grant
    `FFBPA_ASSERT_NOW(a_largest_alone, i_clk, i_rst_n, o_valid && o_largest_free != 8'd0, o_granted_offset == 8'd0)

endmodule

bind first_fit_byte_pool_allocator ffbpa_checker u_ffbpa_checker (.*);

`default_nettype wire
